FILE: rtl/tstr_pkg.sv
// Shared types, codes and constants for the time-sorted record table.
package tstr_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  localparam int TIME_W  = 32;
  localparam int SIZE_W  = 40;
  localparam int TAG_W   = 16;
  localparam int TOTAL_W = 44;
  localparam int COUNT_W = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] ctime;
    logic [SIZE_W-1:0] fsize;
    logic [TAG_W-1:0]  ftag;
  } record_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [TOTAL_W-1:0] total_size;
    logic [COUNT_W-1:0] entry_count;
    logic [TAG_W-1:0]   removed_tag;
    logic [SIZE_W-1:0]  removed_size;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_PUT,
    S_REM_SCAN,
    S_REM_SHIFT,
    S_FINISH
  } state_t;

endpackage

FILE: rtl/tstr_mem.sv
// Record memory with one write port and one registered read port.
module tstr_mem #(
  parameter int DEPTH = tstr_pkg::TABLE_ENTRIES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  tstr_pkg::record_t wr_data,
  input  logic [AW-1:0]     rd_addr,
  output tstr_pkg::record_t rd_data
);

  tstr_pkg::record_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/tstr_seq.sv
// Command sequencer: insert scan with shift, minimum search and removal shift.
module tstr_seq #(
  parameter int TABLE_ENTRIES = tstr_pkg::TABLE_ENTRIES_DEF,
  parameter int AW            = $clog2(TABLE_ENTRIES),
  parameter int CW            = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [tstr_pkg::TIME_W-1:0]   created_time,
  input  logic [tstr_pkg::SIZE_W-1:0]   file_size,
  input  logic [tstr_pkg::TAG_W-1:0]    file_tag,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output tstr_pkg::record_t             wr_data,
  output logic [AW-1:0]                 rd_addr,
  input  tstr_pkg::record_t             rd_data,
  input  logic                          out_free,
  output logic                          res_valid,
  output tstr_pkg::result_t             res
);

  localparam int PW = CW + 1;

  tstr_pkg::state_t state, state_next;

  tstr_pkg::record_t                 new_rec;
  logic [AW-1:0]                     ptr;
  logic [AW-1:0]                     best_idx;
  logic [tstr_pkg::SIZE_W-1:0]       best_size;
  logic [tstr_pkg::TAG_W-1:0]        best_tag;
  logic [CW-1:0]                     count;
  logic [tstr_pkg::TOTAL_W-1:0]      total;
  logic [1:0]                        fin_status;
  logic [tstr_pkg::TAG_W-1:0]        fin_rtag;
  logic [tstr_pkg::SIZE_W-1:0]       fin_rsize;

  logic          accept;
  logic          is_full;
  logic          is_empty;
  logic          ins_shift;
  logic          rem_take;
  logic          rem_last;
  logic          shift_more;
  logic [AW-1:0] final_idx;
  logic [tstr_pkg::SIZE_W-1:0] final_size;
  logic [tstr_pkg::TAG_W-1:0]  final_tag;

  assign accept   = in_valid && !in_stall;
  assign is_full  = (count == CW'(TABLE_ENTRIES));
  assign is_empty = (count == '0);

  assign ins_shift  = (ptr != '0) ? (rd_data.ctime >= new_rec.ctime)
                                  : (new_rec.ctime < rd_data.ctime);
  assign rem_take   = (ptr == '0) || (rd_data.fsize < best_size);
  assign rem_last   = ((PW'(ptr) + PW'(1)) == PW'(count));
  assign shift_more = ((PW'(ptr) + PW'(1)) < PW'(count));
  assign final_idx  = rem_take ? ptr : best_idx;
  assign final_size = rem_take ? rd_data.fsize : best_size;
  assign final_tag  = rem_take ? rd_data.ftag : best_tag;

  always_comb begin
    state_next = state;
    unique case (state)
      tstr_pkg::S_IDLE: begin
        if (accept) begin
          if (command == tstr_pkg::CMD_INSERT) begin
            state_next = (is_full || is_empty) ? tstr_pkg::S_FINISH : tstr_pkg::S_INS_SCAN;
          end else begin
            state_next = is_empty ? tstr_pkg::S_FINISH : tstr_pkg::S_REM_SCAN;
          end
        end
      end
      tstr_pkg::S_INS_SCAN: begin
        if (!ins_shift) begin
          state_next = tstr_pkg::S_FINISH;
        end else if (ptr == '0) begin
          state_next = tstr_pkg::S_INS_PUT;
        end
      end
      tstr_pkg::S_INS_PUT: begin
        state_next = tstr_pkg::S_FINISH;
      end
      tstr_pkg::S_REM_SCAN: begin
        if (rem_last) begin
          state_next = (final_idx == ptr) ? tstr_pkg::S_FINISH : tstr_pkg::S_REM_SHIFT;
        end
      end
      tstr_pkg::S_REM_SHIFT: begin
        if (!shift_more) begin
          state_next = tstr_pkg::S_FINISH;
        end
      end
      tstr_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = tstr_pkg::S_IDLE;
        end
      end
      default: state_next = tstr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = new_rec;
    rd_addr   = '0;
    res_valid = 1'b0;
    unique case (state)
      tstr_pkg::S_IDLE: begin
        in_stall = 1'b0;
        wr_data  = '{ctime: created_time, fsize: file_size, ftag: file_tag};
        wr_en    = accept && (command == tstr_pkg::CMD_INSERT) && is_empty;
        if (command == tstr_pkg::CMD_INSERT) begin
          rd_addr = AW'(count - CW'(1));
        end
      end
      tstr_pkg::S_INS_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = AW'(PW'(ptr) + PW'(1));
        wr_data = ins_shift ? rd_data : new_rec;
        rd_addr = ptr - AW'(1);
      end
      tstr_pkg::S_INS_PUT: begin
        wr_en = 1'b1;
      end
      tstr_pkg::S_REM_SCAN: begin
        rd_addr = rem_last ? AW'(PW'(final_idx) + PW'(1)) : AW'(PW'(ptr) + PW'(1));
      end
      tstr_pkg::S_REM_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = ptr;
        wr_data = rd_data;
        rd_addr = AW'(PW'(ptr) + PW'(2));
      end
      tstr_pkg::S_FINISH: begin
        res_valid = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tstr_pkg::S_IDLE;
      count <= '0;
      total <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        tstr_pkg::S_IDLE: begin
          if (accept && command == tstr_pkg::CMD_INSERT && !is_full && is_empty) begin
            count <= count + CW'(1);
            total <= total + tstr_pkg::TOTAL_W'(file_size);
          end
        end
        tstr_pkg::S_INS_SCAN: begin
          if (!ins_shift) begin
            count <= count + CW'(1);
            total <= total + tstr_pkg::TOTAL_W'(new_rec.fsize);
          end
        end
        tstr_pkg::S_INS_PUT: begin
          count <= count + CW'(1);
          total <= total + tstr_pkg::TOTAL_W'(new_rec.fsize);
        end
        tstr_pkg::S_REM_SCAN: begin
          if (rem_last) begin
            count <= count - CW'(1);
            total <= total - tstr_pkg::TOTAL_W'(final_size);
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      tstr_pkg::S_IDLE: begin
        if (accept) begin
          new_rec   <= '{ctime: created_time, fsize: file_size, ftag: file_tag};
          fin_rtag  <= '0;
          fin_rsize <= '0;
          if (command == tstr_pkg::CMD_INSERT) begin
            fin_status <= is_full ? tstr_pkg::STATUS_FULL : tstr_pkg::STATUS_DONE;
            ptr        <= AW'(count - CW'(1));
          end else begin
            fin_status <= is_empty ? tstr_pkg::STATUS_EMPTY : tstr_pkg::STATUS_DONE;
            ptr        <= '0;
          end
        end
      end
      tstr_pkg::S_INS_SCAN: begin
        if (ins_shift && ptr != '0) begin
          ptr <= ptr - AW'(1);
        end
      end
      tstr_pkg::S_REM_SCAN: begin
        if (rem_take) begin
          best_idx  <= ptr;
          best_size <= rd_data.fsize;
          best_tag  <= rd_data.ftag;
        end
        if (rem_last) begin
          ptr       <= final_idx;
          fin_rtag  <= final_tag;
          fin_rsize <= final_size;
        end else begin
          ptr <= AW'(PW'(ptr) + PW'(1));
        end
      end
      tstr_pkg::S_REM_SHIFT: begin
        ptr <= AW'(PW'(ptr) + PW'(1));
      end
      default: begin
        ptr <= ptr;
      end
    endcase
  end

  assign res = '{status:       fin_status,
                 total_size:   total,
                 entry_count:  tstr_pkg::COUNT_W'(count),
                 removed_tag:  fin_rtag,
                 removed_size: fin_rsize};

endmodule

FILE: rtl/time_sorted_table_remove_smallest.sv
// Top level of the time-sorted record table with smallest-size removal.
//
//   channel  direction  handshake            payload
//   in       inbound    in_valid / in_stall   command, created_time, file_size, file_tag
//   out      outbound   out_valid / out_stall status, total_size, entry_count,
//                                            removed_tag, removed_size
//
// An insert does one memory read per entry scanned from the top of the table,
// with the shift write in the same cycle.
// A remove does a minimum search over all entries through the read port, then
// a shift of the entries above the removed one.
// The input is stalled while a command is in progress; a finished result waits
// in the output register and the next beat can be taken while it waits.
// Reset clears the count and the total; the memory keeps its contents.
module time_sorted_table_remove_smallest #(
  parameter int TABLE_ENTRIES = tstr_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           command,
  input  logic [tstr_pkg::TIME_W-1:0]    created_time,
  input  logic [tstr_pkg::SIZE_W-1:0]    file_size,
  input  logic [tstr_pkg::TAG_W-1:0]     file_tag,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic [tstr_pkg::TOTAL_W-1:0]   total_size,
  output logic [tstr_pkg::COUNT_W-1:0]   entry_count,
  output logic [tstr_pkg::TAG_W-1:0]     removed_tag,
  output logic [tstr_pkg::SIZE_W-1:0]    removed_size
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  tstr_pkg::record_t wr_data;
  logic [AW-1:0]     rd_addr;
  tstr_pkg::record_t rd_data;
  logic              out_free;
  logic              res_valid;
  tstr_pkg::result_t res;
  tstr_pkg::result_t out_reg;

  tstr_mem #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tstr_seq #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .AW            (AW),
    .CW            (CW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .created_time (created_time),
    .file_size    (file_size),
    .file_tag     (file_tag),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .out_free     (out_free),
    .res_valid    (res_valid),
    .res          (res)
  );

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_reg <= res;
    end
  end

  assign status       = out_reg.status;
  assign total_size   = out_reg.total_size;
  assign entry_count  = out_reg.entry_count;
  assign removed_tag  = out_reg.removed_tag;
  assign removed_size = out_reg.removed_size;

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!out_valid || !out_stall))
    else $error("result loaded over a beat that was not taken");

  a_full_count : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == tstr_pkg::STATUS_FULL)
      |-> (res.entry_count == tstr_pkg::COUNT_W'(TABLE_ENTRIES)))
    else $error("insert refused while the table was not full");

  a_empty_fields : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == tstr_pkg::STATUS_EMPTY)
      |-> (res.entry_count == '0 && res.removed_size == '0 && res.removed_tag == '0))
    else $error("empty status with nonzero count or removed fields");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("new beat taken while a command is in progress");

endmodule
